>>> src/fcik_pkg.sv
// shared types, widths, codes and fixed-point helpers for the fabrik chain solver
package fcik_pkg;

  localparam int MAX_JOINTS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int LEN_W      = 31;
  localparam int JIDX_W     = 6;
  localparam int JW         = $clog2(MAX_JOINTS);
  localparam int CW         = $clog2(MAX_JOINTS + 1);
  localparam int DIR_W      = FRAC_BITS + 1;
  localparam int DIV_W      = DATA_W + FRAC_BITS;
  localparam int MUL_CNT_W  = $clog2(DATA_W);
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int MIN_CHAIN  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int ITER_W     = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd2;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic                     first_joint;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic [LEN_W-1:0]         segment_length;
  } in_item_t;

  typedef struct packed {
    logic [JIDX_W-1:0]        joint_index;
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic                     last_joint;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } pos_t;

  typedef enum logic [1:0] {PH_LEN, PH_ERR, PH_FWD, PH_BWD} phase_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_THR, ST_RDA, ST_RDB, ST_DIF, ST_ERRD, ST_SQS, ST_SQW, ST_SQD,
    ST_SRW, ST_DVS, ST_DVW, ST_MLS, ST_MLW, ST_WR, ST_ROOT, ST_ITOP,
    ST_EMIT, ST_EMO
  } state_t;

  // b - a, clamped to the signed word range
  function automatic logic [DATA_W-1:0] sat_sub(input logic [DATA_W-1:0] b,
                                                input logic [DATA_W-1:0] a);
    logic [DATA_W:0] diff;
    diff = {b[DATA_W-1], b} - {a[DATA_W-1], a};
    if (diff[DATA_W] != diff[DATA_W-1])
      return diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    return diff[DATA_W-1:0];
  endfunction

  // base +/- magnitude, clamped to the signed word range
  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] base,
                                                input logic [DATA_W-1:0] mag,
                                                input logic neg);
    logic [DATA_W+1:0] bx, mx, r;
    bx = {{2{base[DATA_W-1]}}, base};
    mx = {2'b00, mag};
    r  = neg ? bx - mx : bx + mx;
    if (r[DATA_W+1] && (r[DATA_W:DATA_W-1] != 2'b11))
      return {1'b1, {(DATA_W-1){1'b0}}};
    if (!r[DATA_W+1] && (r[DATA_W:DATA_W-1] != 2'b00))
      return {1'b0, {(DATA_W-1){1'b1}}};
    return r[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DATA_W-1:0] pos_pick(input pos_t p, input logic [1:0] c);
    logic [DATA_W-1:0] v;
    case (c)
      2'd0:    v = p.x;
      2'd1:    v = p.y;
      default: v = p.z;
    endcase
    return v;
  endfunction

endpackage

>>> src/fcik_mul.sv
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
module fcik_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [fcik_pkg::DATA_W-1:0]    a,
  input  logic [fcik_pkg::DATA_W-1:0]    b,
  output logic                           done,
  output logic [2*fcik_pkg::DATA_W-1:0]  prod
);

  logic                              run_r, run_nxt, done_r, done_nxt;
  logic [fcik_pkg::MUL_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [fcik_pkg::DATA_W-1:0]       a_r, hi_r, lo_r;
  logic [fcik_pkg::DATA_W:0]         sum;

  // conditional add of the multiplicand into the upper half
  assign sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
  assign prod = {hi_r, lo_r};
  assign done = done_r;

  // step control
  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (run_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == {fcik_pkg::MUL_CNT_W{1'b1}}) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // product shift register
  always_ff @(posedge clk) begin
    if (!run_r && start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (run_r) begin
      hi_r <= sum[fcik_pkg::DATA_W:1];
      lo_r <= {sum[0], lo_r[fcik_pkg::DATA_W-1:1]};
    end
  end

endmodule

>>> src/fcik_sqrt.sv
// digit-serial integer square root, two radicand bits per cycle
module fcik_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [2*fcik_pkg::DATA_W-1:0]  radicand,
  output logic                           done,
  output logic [fcik_pkg::DATA_W-1:0]    root
);

  localparam int RW = fcik_pkg::DATA_W + 3;

  logic                              run_r, run_nxt, done_r, done_nxt;
  logic [fcik_pkg::MUL_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [2*fcik_pkg::DATA_W-1:0]     v_r;
  logic [RW-1:0]                     rem_r, rem_sh, trial;
  logic [fcik_pkg::DATA_W-1:0]       root_r;

  // trial subtraction of 4*root+1
  assign rem_sh = {rem_r[RW-3:0], v_r[2*fcik_pkg::DATA_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign root   = root_r;
  assign done   = done_r;

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (run_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == {fcik_pkg::MUL_CNT_W{1'b1}}) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // remainder, root and radicand shift
  always_ff @(posedge clk) begin
    if (!run_r && start) begin
      v_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      v_r <= {v_r[2*fcik_pkg::DATA_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[fcik_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[fcik_pkg::DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> src/fcik_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module fcik_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [fcik_pkg::DIV_W-1:0]   dividend,
  input  logic [fcik_pkg::DATA_W-1:0]  divisor,
  output logic                         done,
  output logic [fcik_pkg::DIV_W-1:0]   quotient
);

  logic                              run_r, run_nxt, done_r, done_nxt;
  logic [fcik_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [fcik_pkg::DIV_W-1:0]        q_r;
  logic [fcik_pkg::DATA_W-1:0]       dv_r, rem_r;
  logic [fcik_pkg::DATA_W:0]         rem_sh;

  assign rem_sh   = {rem_r, q_r[fcik_pkg::DIV_W-1]};
  assign quotient = q_r;
  assign done     = done_r;

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (run_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == fcik_pkg::DIV_CNT_W'(fcik_pkg::DIV_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (!run_r && start) begin
      q_r   <= dividend;
      dv_r  <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      if (rem_sh >= {1'b0, dv_r}) begin
        rem_r <= fcik_pkg::DATA_W'(rem_sh - {1'b0, dv_r});
        q_r   <= {q_r[fcik_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[fcik_pkg::DATA_W-1:0];
        q_r   <= {q_r[fcik_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> src/fabrik_chain_ik_solver.sv
// top level: joint store, fabrik sequencer and serial arithmetic units
//
// Command interface. An item is taken on a clock edge with start high and busy
// low. A load item writes one joint and gives no result; once the store is
// full, only a first-joint load is written. A solve item with n loaded
// joints emits n results, each shown for one cycle with out_strobe high;
// the receiver cannot stall, so it must take every result. busy stays high
// from the solve transfer until the last result is on the ports.
// Solve time is data dependent and set by the shared serial units: a
// multiplier, a square root and a divider. Placing one joint takes three
// squares, a root, then per axis a divide and a scale multiply. With fewer
// than two joints a solve only emits.
// Configuration writes are always taken (cfg_ready is high) and are meant
// for idle periods. Reset (rst_n low, synchronous) empties the chain, zeroes
// the root and restores the register defaults.
module fabrik_chain_ik_solver (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  fcik_pkg::in_item_t               in_data,
  output logic                             out_strobe,
  output fcik_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fcik_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcik_pkg::DATA_W-1:0]      cfg_data
);

  localparam int DW = fcik_pkg::DATA_W;
  localparam int JW = fcik_pkg::JW;
  localparam int CW = fcik_pkg::CW;
  localparam int LW = fcik_pkg::LEN_W;
  localparam int FB = fcik_pkg::FRAC_BITS;

  // control state
  fcik_pkg::state_t          state_r, state_nxt;
  fcik_pkg::phase_t          ph_r, ph_nxt;
  logic [JW-1:0]             j_r, j_nxt;
  logic [CW-1:0]             n_r, n_nxt, count_r, count_nxt;
  logic [fcik_pkg::ITER_W-1:0] it_r, it_nxt, maxit_r;
  logic [1:0]                comp_r, comp_nxt;
  logic                      mode_r;
  logic [LW-1:0]             thr_r;
  logic                      out_strobe_r, out_strobe_nxt;
  fcik_pkg::pos_t            root_r, root_nxt;

  // datapath
  fcik_pkg::pos_t            tgt_r, tgt_nxt, d_r, d_nxt, a_r, a_nxt, b_r, b_nxt;
  fcik_pkg::pos_t            new_r, new_nxt;
  logic [2*DW-1:0]           thr2_r, thr2_nxt, acc_r, acc_nxt;
  logic [LW-1:0]             len_r, len_nxt, seg_r, seg_nxt;
  logic [DW-1:0]             m_r, m_nxt;
  logic [fcik_pkg::DIR_W-1:0] q_r, q_nxt;
  fcik_pkg::out_item_t       out_r, out_nxt;

  // memories
  fcik_pkg::pos_t            mem_pos [fcik_pkg::MAX_JOINTS];
  logic [LW-1:0]             mem_seg [fcik_pkg::MAX_JOINTS];
  logic [LW-1:0]             mem_wlen[fcik_pkg::MAX_JOINTS];
  fcik_pkg::pos_t            rd_pos_r;
  logic [LW-1:0]             rd_seg_r, rd_wlen_r;
  logic [JW-1:0]             rd_addr, pos_wa;
  logic                      pos_we, seg_we, wlen_we;
  fcik_pkg::pos_t            pos_wd;
  logic [LW-1:0]             wlen_wd;

  // serial units
  logic                      mul_start, mul_done, sqrt_start, sqrt_done;
  logic                      div_start, div_done;
  logic [DW-1:0]             mul_a, mul_b, sqrt_root;
  logic [2*DW-1:0]           mul_prod;
  logic [fcik_pkg::DIV_W-1:0] div_dividend, div_quot;

  // per-axis helpers
  logic [DW-1:0]             d_cur, d_mag, s_val, base_cur, placed;
  logic                      neg_cur, advance;
  logic [CW-1:0]             load_idx;

  assign cfg_ready  = 1'b1;
  assign busy       = (state_r != fcik_pkg::ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  assign d_cur    = fcik_pkg::pos_pick(d_r, comp_r);
  assign d_mag    = fcik_pkg::mag32(d_cur);
  assign s_val    = mul_prod[FB +: DW];
  assign base_cur = (ph_r == fcik_pkg::PH_FWD) ? fcik_pkg::pos_pick(b_r, comp_r)
                                               : fcik_pkg::pos_pick(a_r, comp_r);
  assign neg_cur  = d_cur[DW-1] ^ (ph_r == fcik_pkg::PH_FWD);
  assign placed   = fcik_pkg::sat_add(base_cur, s_val, neg_cur);
  assign load_idx = in_data.first_joint ? '0 : count_r;
  assign div_dividend = {d_mag, {FB{1'b0}}};

  fcik_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  fcik_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .radicand(acc_r),
    .done(sqrt_done), .root(sqrt_root)
  );

  fcik_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(m_r), .done(div_done), .quotient(div_quot)
  );

  // joint store, segment store and working lengths, registered reads
  always_ff @(posedge clk) begin
    if (pos_we) mem_pos[pos_wa] <= pos_wd;
    if (seg_we) mem_seg[pos_wa] <= in_data.segment_length;
    if (wlen_we) mem_wlen[j_r] <= wlen_wd;
    rd_pos_r  <= mem_pos[rd_addr];
    rd_seg_r  <= mem_seg[rd_addr];
    rd_wlen_r <= mem_wlen[rd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    ph_nxt         = ph_r;
    j_nxt          = j_r;
    n_nxt          = n_r;
    it_nxt         = it_r;
    comp_nxt       = comp_r;
    count_nxt      = count_r;
    root_nxt       = root_r;
    out_strobe_nxt = 1'b0;
    tgt_nxt        = tgt_r;
    d_nxt          = d_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    new_nxt        = new_r;
    thr2_nxt       = thr2_r;
    acc_nxt        = acc_r;
    len_nxt        = len_r;
    seg_nxt        = seg_r;
    m_nxt          = m_r;
    q_nxt          = q_r;
    out_nxt        = out_r;
    rd_addr        = j_r;
    pos_we         = 1'b0;
    pos_wa         = j_r;
    pos_wd         = new_r;
    seg_we         = 1'b0;
    wlen_we        = 1'b0;
    wlen_wd        = seg_r;
    mul_start      = 1'b0;
    mul_a          = d_mag;
    mul_b          = d_mag;
    sqrt_start     = 1'b0;
    div_start      = 1'b0;
    advance        = 1'b0;

    unique case (state_r)
      fcik_pkg::ST_IDLE: begin
        mul_a = {1'b0, thr_r};
        mul_b = {1'b0, thr_r};
        if (start) begin
          if (in_data.operation == fcik_pkg::OP_LOAD) begin
            if (in_data.first_joint || (count_r != CW'(fcik_pkg::MAX_JOINTS))) begin
              pos_we    = 1'b1;
              seg_we    = 1'b1;
              pos_wa    = load_idx[JW-1:0];
              pos_wd    = '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z};
              count_nxt = load_idx + 1'b1;
              if (load_idx == '0) root_nxt = pos_wd;
            end
          end else begin
            tgt_nxt = '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z};
            n_nxt   = count_r;
            j_nxt   = '0;
            if (count_r >= CW'(fcik_pkg::MIN_CHAIN)) begin
              mul_start = 1'b1;
              state_nxt = fcik_pkg::ST_THR;
            end else if (count_r != '0) begin
              state_nxt = fcik_pkg::ST_EMIT;
            end
          end
        end
      end
      fcik_pkg::ST_THR: begin
        if (mul_done) begin
          thr2_nxt  = mul_prod;
          ph_nxt    = fcik_pkg::PH_LEN;
          state_nxt = fcik_pkg::ST_RDA;
        end
      end
      fcik_pkg::ST_RDA: begin
        state_nxt = fcik_pkg::ST_RDB;
      end
      fcik_pkg::ST_RDB: begin
        rd_addr   = j_r + 1'b1;
        a_nxt     = rd_pos_r;
        seg_nxt   = rd_seg_r;
        len_nxt   = rd_wlen_r;
        state_nxt = fcik_pkg::ST_DIF;
      end
      fcik_pkg::ST_DIF: begin
        b_nxt   = rd_pos_r;
        d_nxt.x = fcik_pkg::sat_sub(rd_pos_r.x, a_r.x);
        d_nxt.y = fcik_pkg::sat_sub(rd_pos_r.y, a_r.y);
        d_nxt.z = fcik_pkg::sat_sub(rd_pos_r.z, a_r.z);
        if ((ph_r == fcik_pkg::PH_LEN) && mode_r) begin
          wlen_we = 1'b1;
          advance = 1'b1;
        end else begin
          comp_nxt  = '0;
          acc_nxt   = '0;
          state_nxt = fcik_pkg::ST_SQS;
        end
      end
      fcik_pkg::ST_ERRD: begin
        d_nxt.x   = fcik_pkg::sat_sub(rd_pos_r.x, tgt_r.x);
        d_nxt.y   = fcik_pkg::sat_sub(rd_pos_r.y, tgt_r.y);
        d_nxt.z   = fcik_pkg::sat_sub(rd_pos_r.z, tgt_r.z);
        comp_nxt  = '0;
        acc_nxt   = '0;
        state_nxt = fcik_pkg::ST_SQS;
      end
      // squared length, one axis per product
      fcik_pkg::ST_SQS: begin
        mul_start = 1'b1;
        state_nxt = fcik_pkg::ST_SQW;
      end
      fcik_pkg::ST_SQW: begin
        if (mul_done) begin
          acc_nxt = acc_r + mul_prod;
          if (comp_r == 2'd2) begin
            state_nxt = fcik_pkg::ST_SQD;
          end else begin
            comp_nxt  = comp_r + 1'b1;
            state_nxt = fcik_pkg::ST_SQS;
          end
        end
      end
      fcik_pkg::ST_SQD: begin
        if (ph_r == fcik_pkg::PH_ERR) begin
          if (acc_r < thr2_r) begin
            j_nxt     = '0;
            state_nxt = fcik_pkg::ST_EMIT;
          end else begin
            pos_we = 1'b1;
            pos_wa = JW'(n_r - 1'b1);
            pos_wd = tgt_r;
            if (n_r == CW'(fcik_pkg::MIN_CHAIN)) begin
              state_nxt = fcik_pkg::ST_ROOT;
            end else begin
              j_nxt     = JW'(n_r - CW'(2));
              ph_nxt    = fcik_pkg::PH_FWD;
              state_nxt = fcik_pkg::ST_RDA;
            end
          end
        end else begin
          sqrt_start = 1'b1;
          state_nxt  = fcik_pkg::ST_SRW;
        end
      end
      fcik_pkg::ST_SRW: begin
        if (sqrt_done) begin
          m_nxt = sqrt_root;
          if (ph_r == fcik_pkg::PH_LEN) begin
            wlen_we = 1'b1;
            wlen_wd = sqrt_root[DW-1] ? {LW{1'b1}} : sqrt_root[LW-1:0];
            advance = 1'b1;
          end else begin
            comp_nxt  = '0;
            state_nxt = fcik_pkg::ST_DVS;
          end
        end
      end
      // unit direction per axis, then scaled step
      fcik_pkg::ST_DVS: begin
        if (m_r == '0) begin
          q_nxt     = '0;
          state_nxt = fcik_pkg::ST_MLS;
        end else begin
          div_start = 1'b1;
          state_nxt = fcik_pkg::ST_DVW;
        end
      end
      fcik_pkg::ST_DVW: begin
        if (div_done) begin
          q_nxt     = div_quot[fcik_pkg::DIR_W-1:0];
          state_nxt = fcik_pkg::ST_MLS;
        end
      end
      fcik_pkg::ST_MLS: begin
        mul_a     = DW'(q_r);
        mul_b     = {1'b0, len_r};
        mul_start = 1'b1;
        state_nxt = fcik_pkg::ST_MLW;
      end
      fcik_pkg::ST_MLW: begin
        if (mul_done) begin
          case (comp_r)
            2'd0:    new_nxt.x = placed;
            2'd1:    new_nxt.y = placed;
            default: new_nxt.z = placed;
          endcase
          if (comp_r == 2'd2) begin
            state_nxt = fcik_pkg::ST_WR;
          end else begin
            comp_nxt  = comp_r + 1'b1;
            state_nxt = fcik_pkg::ST_DVS;
          end
        end
      end
      fcik_pkg::ST_WR: begin
        pos_we  = 1'b1;
        pos_wa  = (ph_r == fcik_pkg::PH_FWD) ? j_r : j_r + 1'b1;
        advance = 1'b1;
      end
      fcik_pkg::ST_ROOT: begin
        pos_we    = 1'b1;
        pos_wa    = '0;
        pos_wd    = root_r;
        j_nxt     = '0;
        ph_nxt    = fcik_pkg::PH_BWD;
        state_nxt = fcik_pkg::ST_RDA;
      end
      fcik_pkg::ST_ITOP: begin
        rd_addr = JW'(n_r - 1'b1);
        if (it_r == maxit_r) begin
          j_nxt     = '0;
          state_nxt = fcik_pkg::ST_EMIT;
        end else begin
          ph_nxt    = fcik_pkg::PH_ERR;
          state_nxt = fcik_pkg::ST_ERRD;
        end
      end
      // result emission: read a joint, then emit it, until the last one
      fcik_pkg::ST_EMIT: begin
        state_nxt = fcik_pkg::ST_EMO;
      end
      fcik_pkg::ST_EMO: begin
        out_strobe_nxt      = 1'b1;
        out_nxt.joint_index = fcik_pkg::JIDX_W'(j_r);
        out_nxt.out_x       = rd_pos_r.x;
        out_nxt.out_y       = rd_pos_r.y;
        out_nxt.out_z       = rd_pos_r.z;
        out_nxt.last_joint  = (CW'(j_r) + 1'b1 == n_r);
        if (CW'(j_r) + 1'b1 == n_r) begin
          state_nxt = fcik_pkg::ST_IDLE;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = fcik_pkg::ST_EMIT;
        end
      end
      default: state_nxt = fcik_pkg::ST_IDLE;
    endcase

    // move to the next segment of the current pass
    if (advance) begin
      unique case (ph_r)
        fcik_pkg::PH_LEN: begin
          if (CW'(j_r) + CW'(2) == n_r) begin
            it_nxt    = '0;
            state_nxt = fcik_pkg::ST_ITOP;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = fcik_pkg::ST_RDA;
          end
        end
        fcik_pkg::PH_FWD: begin
          if (j_r == JW'(1)) begin
            state_nxt = fcik_pkg::ST_ROOT;
          end else begin
            j_nxt     = j_r - 1'b1;
            state_nxt = fcik_pkg::ST_RDA;
          end
        end
        fcik_pkg::PH_BWD: begin
          if (CW'(j_r) + CW'(2) == n_r) begin
            it_nxt    = it_r + 1'b1;
            state_nxt = fcik_pkg::ST_ITOP;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = fcik_pkg::ST_RDA;
          end
        end
        default: state_nxt = fcik_pkg::ST_IDLE;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fcik_pkg::ST_IDLE;
      ph_r         <= fcik_pkg::PH_LEN;
      j_r          <= '0;
      n_r          <= '0;
      it_r         <= '0;
      comp_r       <= '0;
      count_r      <= '0;
      root_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ph_r         <= ph_nxt;
      j_r          <= j_nxt;
      n_r          <= n_nxt;
      it_r         <= it_nxt;
      comp_r       <= comp_nxt;
      count_r      <= count_nxt;
      root_r       <= root_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    tgt_r  <= tgt_nxt;
    d_r    <= d_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    new_r  <= new_nxt;
    thr2_r <= thr2_nxt;
    acc_r  <= acc_nxt;
    len_r  <= len_nxt;
    seg_r  <= seg_nxt;
    m_r    <= m_nxt;
    q_r    <= q_nxt;
    out_r  <= out_nxt;
  end

  // configuration register transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      maxit_r <= fcik_pkg::ITER_W'(10);
      thr_r   <= LW'(655);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fcik_pkg::CFG_LENGTH_MODE: mode_r  <= cfg_data[0];
        fcik_pkg::CFG_MAX_ITER:    maxit_r <= cfg_data[fcik_pkg::ITER_W-1:0];
        fcik_pkg::CFG_THRESHOLD:   thr_r   <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

endmodule
